[rtl/core/imh_pkg.sv]
`timescale 1ns / 1ps
// imh_pkg: shared types, opcodes and status codes of the indexed min-heap.
// No dependencies.
package imh_pkg;

    localparam int NODE_W     = 10;
    localparam int NODE_SLOTS = 1024;
    localparam int KEY_IN_W   = 32;
    localparam int CNT_OUT_W  = 11;
    localparam int STAT_W     = 3;
    localparam int DEF_CAPACITY = 1024;
    localparam int DEF_KEY_BITS = 32;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_DEC  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_PRESENT  = 3'd3;
    localparam logic [STAT_W-1:0] ST_ABSENT   = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOT_LESS = 3'd5;

    typedef struct packed {
        op_t                 op;
        logic [NODE_W-1:0]   node;
        logic [KEY_IN_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [NODE_W-1:0]    node;
        logic [KEY_IN_W-1:0]  key;
        logic [STAT_W-1:0]    status;
        logic [CNT_OUT_W-1:0] count;
        logic                 empty;
    } res_t;

endpackage

[rtl/core/imh_ctrl.sv]
`timescale 1ns / 1ps
// imh_ctrl: heap and position memories, sift sequencer and shared key comparator.
// Depends on imh_pkg.
module imh_ctrl
    import imh_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int KEY_BITS = DEF_KEY_BITS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic idle,
    output logic done,
    input  logic ack,
    output res_t res
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = PW + 2;
    localparam int EW = NODE_W + KEY_BITS;
    localparam int MW = PW + 1;

    typedef enum logic [14:0] {
        S_CLR  = 15'b000000000000001,
        S_IDLE = 15'b000000000000010,
        S_MAP  = 15'b000000000000100,
        S_DEC  = 15'b000000000001000,
        S_UP   = 15'b000000000010000,
        S_UPW  = 15'b000000000100000,
        S_SW1  = 15'b000000001000000,
        S_SW2  = 15'b000000010000000,
        S_POPR = 15'b000000100000000,
        S_POPL = 15'b000001000000000,
        S_DN   = 15'b000010000000000,
        S_DNL  = 15'b000100000000000,
        S_DNR  = 15'b001000000000000,
        S_DNX  = 15'b010000000000000,
        S_DONE = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [EW-1:0] heap_mem [CAPACITY];
    logic [MW-1:0] map_mem  [NODE_SLOTS];
    logic [EW-1:0] heap_q;
    logic [MW-1:0] map_q;

    logic          heap_we;
    logic [PW-1:0] heap_waddr, heap_raddr;
    logic [EW-1:0] heap_wdata;
    logic              map_we;
    logic [NODE_W-1:0] map_waddr, map_raddr;
    logic [MW-1:0]     map_wdata;

    op_t               op_reg, op_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [PW-1:0]     at_reg, at_next, best_reg, best_next;
    logic [NODE_W-1:0] cnode_reg, cnode_next, bnode_reg, bnode_next;
    logic [KEY_BITS-1:0] ckey_reg, ckey_next, bkey_reg, bkey_next;
    logic [NODE_W-1:0] rnode_reg, rnode_next;
    logic [KEY_BITS-1:0] rkey_reg, rkey_next;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic [NODE_W-1:0] clr_reg, clr_next;

    logic [NODE_W-1:0]   hq_node;
    logic [KEY_BITS-1:0] hq_key;
    logic [KEY_BITS-1:0] cmp_a, cmp_b;
    logic                cmp_lt;
    logic [LW-1:0]       left_w, right_w, cnt_w, pos_w;
    logic [PW-1:0]       parent;

    assign hq_node = heap_q[EW-1:KEY_BITS];
    assign hq_key  = heap_q[KEY_BITS-1:0];
    assign cmp_lt  = cmp_a < cmp_b;
    assign left_w  = {1'b0, at_reg, 1'b1};
    assign right_w = left_w + LW'(1);
    assign cnt_w   = LW'(cnt_reg);
    assign pos_w   = LW'(map_q[PW-1:0]);
    assign parent  = (at_reg - PW'(1)) >> 1;

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_waddr] <= heap_wdata;
        end
        heap_q <= heap_mem[heap_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_q <= map_mem[map_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        node_next  = node_reg;
        key_next   = key_reg;
        cnt_next   = cnt_reg;
        at_next    = at_reg;
        best_next  = best_reg;
        cnode_next = cnode_reg;
        ckey_next  = ckey_reg;
        bnode_next = bnode_reg;
        bkey_next  = bkey_reg;
        rnode_next = rnode_reg;
        rkey_next  = rkey_reg;
        stat_next  = stat_reg;
        clr_next   = clr_reg;
        heap_we    = 1'b0;
        heap_waddr = at_reg;
        heap_wdata = {cnode_reg, ckey_reg};
        heap_raddr = '0;
        map_we     = 1'b0;
        map_waddr  = cnode_reg;
        map_wdata  = {1'b1, at_reg};
        map_raddr  = req.node;
        cmp_a      = ckey_reg;
        cmp_b      = hq_key;

        case (state_reg)
            S_CLR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                map_wdata = '0;
                clr_next  = clr_reg + NODE_W'(1);
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = req.op;
                    node_next  = req.node;
                    key_next   = KEY_BITS'(req.key);
                    rnode_next = '0;
                    rkey_next  = '0;
                    stat_next  = ST_OK;
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                case (op_reg)
                    OP_PUSH:
                    begin
                        if (map_q[PW])
                        begin
                            stat_next  = ST_PRESENT;
                            state_next = S_DONE;
                        end
                        else if (cnt_reg >= CW'(CAPACITY))
                        begin
                            stat_next  = ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            heap_we    = 1'b1;
                            heap_waddr = PW'(cnt_reg);
                            heap_wdata = {node_reg, key_reg};
                            map_we     = 1'b1;
                            map_waddr  = node_reg;
                            map_wdata  = {1'b1, PW'(cnt_reg)};
                            cnode_next = node_reg;
                            ckey_next  = key_reg;
                            at_next    = PW'(cnt_reg);
                            cnt_next   = cnt_reg + CW'(1);
                            state_next = S_UP;
                        end
                    end
                    OP_POP:
                    begin
                        if (cnt_reg == '0)
                        begin
                            stat_next  = ST_EMPTY;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            heap_raddr = '0;
                            state_next = S_POPR;
                        end
                    end
                    OP_DEC:
                    begin
                        if (!map_q[PW] || pos_w >= cnt_w)
                        begin
                            stat_next  = ST_ABSENT;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            heap_raddr = map_q[PW-1:0];
                            at_next    = map_q[PW-1:0];
                            state_next = S_DEC;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DEC:
            begin
                cmp_a = key_reg;
                if (cmp_lt)
                begin
                    heap_we    = 1'b1;
                    heap_wdata = {hq_node, key_reg};
                    cnode_next = hq_node;
                    ckey_next  = key_reg;
                    state_next = S_UP;
                end
                else
                begin
                    stat_next  = ST_NOT_LESS;
                    state_next = S_DONE;
                end
            end
            S_UP:
            begin
                heap_raddr = parent;
                state_next = (at_reg == '0) ? S_DONE : S_UPW;
            end
            S_UPW:
            begin
                if (cmp_lt)
                begin
                    best_next  = parent;
                    bnode_next = hq_node;
                    bkey_next  = hq_key;
                    state_next = S_SW1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SW1:
            begin
                heap_we    = 1'b1;
                heap_waddr = best_reg;
                map_we     = 1'b1;
                map_wdata  = {1'b1, best_reg};
                state_next = S_SW2;
            end
            S_SW2:
            begin
                heap_we    = 1'b1;
                heap_wdata = {bnode_reg, bkey_reg};
                map_we     = 1'b1;
                map_waddr  = bnode_reg;
                at_next    = best_reg;
                state_next = (op_reg == OP_POP) ? S_DN : S_UP;
            end
            S_POPR:
            begin
                rnode_next = hq_node;
                rkey_next  = hq_key;
                map_we     = 1'b1;
                map_waddr  = hq_node;
                map_wdata  = '0;
                cnt_next   = cnt_reg - CW'(1);
                heap_raddr = PW'(cnt_reg - CW'(1));
                state_next = (cnt_reg == CW'(1)) ? S_DONE : S_POPL;
            end
            S_POPL:
            begin
                heap_we    = 1'b1;
                heap_waddr = '0;
                heap_wdata = heap_q;
                map_we     = 1'b1;
                map_waddr  = hq_node;
                map_wdata  = {1'b1, PW'(0)};
                cnode_next = hq_node;
                ckey_next  = hq_key;
                at_next    = '0;
                state_next = S_DN;
            end
            S_DN:
            begin
                heap_raddr = left_w[PW-1:0];
                state_next = (left_w >= cnt_w) ? S_DONE : S_DNL;
            end
            S_DNL:
            begin
                cmp_a = hq_key;
                cmp_b = ckey_reg;
                if (cmp_lt)
                begin
                    best_next  = left_w[PW-1:0];
                    bnode_next = hq_node;
                    bkey_next  = hq_key;
                end
                else
                begin
                    best_next = at_reg;
                    bkey_next = ckey_reg;
                end
                heap_raddr = right_w[PW-1:0];
                state_next = (right_w < cnt_w) ? S_DNR : S_DNX;
            end
            S_DNR:
            begin
                cmp_a = hq_key;
                cmp_b = bkey_reg;
                if (cmp_lt)
                begin
                    best_next  = right_w[PW-1:0];
                    bnode_next = hq_node;
                    bkey_next  = hq_key;
                end
                state_next = S_DNX;
            end
            S_DNX:
            begin
                state_next = (best_reg == at_reg) ? S_DONE : S_SW1;
            end
            S_DONE:
            begin
                if (ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        node_reg  <= node_next;
        key_reg   <= key_next;
        at_reg    <= at_next;
        best_reg  <= best_next;
        cnode_reg <= cnode_next;
        ckey_reg  <= ckey_next;
        bnode_reg <= bnode_next;
        bkey_reg  <= bkey_next;
        rnode_reg <= rnode_next;
        rkey_reg  <= rkey_next;
        stat_reg  <= stat_next;
    end

    assign idle       = (state_reg == S_IDLE);
    assign done       = (state_reg == S_DONE);
    assign res.node   = rnode_reg;
    assign res.key    = KEY_IN_W'(rkey_reg);
    assign res.status = stat_reg;
    assign res.count  = CNT_OUT_W'(cnt_reg);
    assign res.empty  = (cnt_reg == '0);

endmodule

[rtl/core/indexed_min_heap.sv]
`timescale 1ns / 1ps
// indexed_min_heap: top level, request intake and result register.
// Depends on imh_pkg and imh_ctrl.
//
// Indexed binary min-heap. A request (op, node_id, key) pushes a node,
// pops the minimum or lowers a queued node's key; each request gives one
// result (out_node, out_key, status, count, empty_res).
// Both channels use valid/ready; a request is taken when in_valid and
// in_ready are high, a result when out_valid and out_ready are high.
// One request at a time: in_ready is high only while the sequencer is idle.
// A rejected request ends without a sift. A sift walks the heap one
// level at a time, up for a push or a key decrease and down for a pop;
// its pace is set by the single read and write port of the heap memory
// and the shared key comparator.
// After reset the position map is swept clear, one entry a cycle, over all
// 1024 entries with in_ready low. The heap memory itself is not cleared.
// A held result stays in the output register while out_ready is low; the
// sequencer waits to hand over its next result, so nothing is dropped.
module indexed_min_heap
    import imh_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int KEY_BITS = DEF_KEY_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           op,
    input  logic [NODE_W-1:0]    node_id,
    input  logic [KEY_IN_W-1:0]  key,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [NODE_W-1:0]    out_node,
    output logic [KEY_IN_W-1:0]  out_key,
    output logic [STAT_W-1:0]    status,
    output logic [CNT_OUT_W-1:0] count,
    output logic                 empty_res
);

    req_t req;
    res_t res, res_reg;
    logic idle, done, ack;
    logic out_valid_reg, out_valid_next;

    assign req.op   = op_t'(op);
    assign req.node = node_id;
    assign req.key  = key;

    imh_ctrl #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_valid && idle),
        .req   (req),
        .idle  (idle),
        .done  (done),
        .ack   (ack),
        .res   (res)
    );

    assign in_ready = idle;
    assign ack      = done && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ack)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ack)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_node  = res_reg.node;
    assign out_key   = res_reg.key;
    assign status    = res_reg.status;
    assign count     = res_reg.count;
    assign empty_res = res_reg.empty;

endmodule
